[rtl/stt_pkg.sv]
`default_nettype none
package stt_pkg;

    localparam int POSITION_BITS_DEF   = 16;
    localparam int LONGEST_KEYWORD_DEF = 7;
    localparam int MAX_RESULTS         = 3;

    localparam logic [5:0] K_STRING    = 6'd48;
    localparam logic [5:0] K_AT_NATIVE = 6'd49;
    localparam logic [5:0] K_NUMBER    = 6'd50;
    localparam logic [5:0] K_IDENT     = 6'd51;
    localparam logic [5:0] K_NONE      = 6'd63;
    localparam logic [5:0] K_COMMENT   = 6'd62;

    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_BYTE   = 2'd1;
    localparam logic [1:0] E_STRING = 2'd2;
    localparam logic [1:0] E_AT     = 2'd3;

    // one result item
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] length;
        logic [1:0]  err;
        logic        done;
        logic        last;
    } t_result;

    // up to three results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_group;

    // operator with a possible two-character form
    function automatic logic is_pair(input logic [7:0] c);
        case (c)
            "&", "|", "+", "-", "/", "*", "%", "^", "!", "=", ">", "<": is_pair = 1'b1;
            default: is_pair = 1'b0;
        endcase
    endfunction

    function automatic logic [5:0] pair_single(input logic [7:0] c);
        case (c)
            "&": pair_single = 6'd9;
            "|": pair_single = 6'd11;
            "+": pair_single = 6'd14;
            "-": pair_single = 6'd17;
            "/": pair_single = 6'd19;
            "*": pair_single = 6'd21;
            "%": pair_single = 6'd23;
            "^": pair_single = 6'd25;
            "!": pair_single = 6'd27;
            "=": pair_single = 6'd29;
            ">": pair_single = 6'd31;
            "<": pair_single = 6'd33;
            default: pair_single = K_NONE;
        endcase
    endfunction

    // the "c=" form is always one code below the single form
    function automatic logic [5:0] pair_double(input logic [7:0] c);
        case (c)
            "+": pair_double = 6'd12;
            "-": pair_double = 6'd15;
            "/": pair_double = K_COMMENT;
            default: pair_double = K_NONE;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        is_numeral = c >= "0" && c <= "9";
    endfunction

endpackage
`default_nettype wire

[rtl/stt_front.sv]
`default_nettype none
module stt_front
    import stt_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int LONGEST_KEYWORD = LONGEST_KEYWORD_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    input  wire logic       i_take,
    output t_group          o_group,
    output logic            o_push
);

    typedef enum logic [3:0] {
        S_IDLE, S_OP, S_COMMENT, S_WORD, S_AT, S_NUMBER, S_STRING, S_ESC
    } t_mode;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [15:0] SAT = 16'hFFFF;
    localparam int LW = $clog2(LONGEST_KEYWORD + 1);

    t_mode                    r_mode, n_mode;
    logic [7:0]               r_pend, n_pend;
    logic [7:0]               r_pref [LONGEST_KEYWORD];
    logic [15:0]              r_len, n_len;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [POSITION_BITS-1:0] r_pos;
    logic [15:0]              r_line, n_line;
    logic                     r_err, n_err;

    t_group   g;
    logic     wr_en;
    logic [LW-1:0] wr_idx;

    // compare the held word against a keyword of a given length
    function automatic logic kw(input logic [7:0] p [LONGEST_KEYWORD], input logic [15:0] n,
                                input logic [55:0] s, input int l);
        logic ok;
        ok = (n == 16'(l));
        for (int i = 0; i < 7; i++)
            if (i < l && p[i] != s[8*(l-1-i) +: 8]) ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [5:0] word_kind(input logic [7:0] p [LONGEST_KEYWORD],
                                             input logic [15:0] n);
        logic [5:0] k;
        k = K_IDENT;
        if (kw(p, n, 56'("for"), 3))    k = 6'd34;
        if (kw(p, n, 56'("false"), 5))  k = 6'd35;
        if (kw(p, n, 56'("return"), 6)) k = 6'd36;
        if (kw(p, n, 56'("if"), 2))     k = 6'd37;
        if (kw(p, n, 56'("int"), 3))    k = 6'd38;
        if (kw(p, n, 56'("else"), 4))   k = 6'd39;
        if (kw(p, n, 56'("while"), 5))  k = 6'd40;
        if (kw(p, n, 56'("and"), 3))    k = 6'd41;
        if (kw(p, n, 56'("or"), 2))     k = 6'd42;
        if (kw(p, n, 56'("print"), 5))  k = 6'd43;
        if (kw(p, n, 56'("char"), 4))   k = 6'd44;
        if (kw(p, n, 56'("long"), 4))   k = 6'd45;
        if (kw(p, n, 56'("bool"), 4))   k = 6'd46;
        if (kw(p, n, 56'("true"), 4))   k = 6'd47;
        return k;
    endfunction

    function automatic logic [15:0] lo16(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    // classify one byte against the current scan state
    always_comb begin
        logic used, e;
        logic [POSITION_BITS-1:0] after;
        t_result rs [3];
        logic [1:0] cnt;
        logic [7:0] pv [LONGEST_KEYWORD];
        n_mode = r_mode; n_pend = r_pend; n_len = r_len; n_begin = r_begin;
        n_line = r_line; n_err = r_err;
        wr_en = 1'b0; wr_idx = '0;
        cnt = 2'd0; used = 1'b0; e = i_end;
        for (int i = 0; i < 3; i++) rs[i] = '0;
        for (int i = 0; i < LONGEST_KEYWORD; i++) pv[i] = r_pref[i];
        after = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

        if (!r_err) begin
            // continue a token in progress
            case (r_mode)
                S_OP: begin
                    if (i_byte == "=") begin
                        rs[cnt] = '{pair_single(r_pend) - 6'd1, r_line, lo16(r_begin), 16'd2,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE; used = 1'b1;
                    end else if (i_byte == r_pend && pair_double(r_pend) != K_NONE) begin
                        used = 1'b1;
                        if (pair_double(r_pend) == K_COMMENT) n_mode = S_COMMENT;
                        else begin
                            rs[cnt] = '{pair_double(r_pend), r_line, lo16(r_begin), 16'd2,
                                        E_NONE, 1'b0, 1'b0};
                            cnt = cnt + 1'b1; n_mode = S_IDLE;
                        end
                    end else begin
                        rs[cnt] = '{pair_single(r_pend), r_line, lo16(r_begin), 16'd1,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE;
                    end
                end
                S_COMMENT: begin
                    used = 1'b1;
                    if (i_byte == "\n") begin
                        if (n_line != SAT) n_line = n_line + 1'b1;
                        n_mode = S_IDLE;
                    end
                end
                S_WORD, S_AT: begin
                    if (is_alpha(i_byte) || is_numeral(i_byte)) begin
                        used = 1'b1;
                        if (r_len < 16'(LONGEST_KEYWORD)) begin
                            wr_en = 1'b1; wr_idx = r_len[LW-1:0];
                        end
                        if (n_len != SAT) n_len = n_len + 1'b1;
                    end else if (r_mode == S_WORD) begin
                        rs[cnt] = '{word_kind(r_pref, r_len), r_line, lo16(r_begin), r_len,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE;
                    end else if (kw(r_pref, r_len, 56'("@native"), 7)) begin
                        rs[cnt] = '{K_AT_NATIVE, r_line, lo16(r_begin), 16'd7,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE;
                    end else begin
                        rs[cnt] = '{6'd0, r_line, lo16(r_begin), 16'd0, E_AT, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE; n_err = 1'b1;
                    end
                end
                S_NUMBER: begin
                    if (is_numeral(i_byte)) begin
                        used = 1'b1;
                        if (n_len != SAT) n_len = n_len + 1'b1;
                    end else begin
                        rs[cnt] = '{K_NUMBER, r_line, lo16(r_begin), r_len,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE;
                    end
                end
                S_STRING: begin
                    used = 1'b1;
                    if (i_byte == "\"") begin
                        rs[cnt] = '{K_STRING, r_line, lo16(r_begin), r_len,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE;
                    end else if (i_byte == "\n") begin
                        rs[cnt] = '{6'd0, r_line, lo16(r_begin), 16'd0, E_STRING, 1'b0, 1'b0};
                        cnt = cnt + 1'b1; n_mode = S_IDLE; n_err = 1'b1;
                    end else begin
                        if (i_byte == "\\") n_mode = S_ESC;
                        if (n_len != SAT) n_len = n_len + 1'b1;
                    end
                end
                S_ESC: begin
                    used = 1'b1;
                    if (n_len != SAT) n_len = n_len + 1'b1;
                    n_mode = S_STRING;
                end
                default: n_mode = S_IDLE;
            endcase

            // start a new token
            if (!used && !n_err) begin
                case (i_byte)
                    " ", "\r", "\t": ;
                    "\n": if (n_line != SAT) n_line = n_line + 1'b1;
                    "(", ")", "{", "}", ",", ".", ";", "~": begin
                        case (i_byte)
                            "(": rs[cnt].kind = 6'd0;
                            ")": rs[cnt].kind = 6'd1;
                            "{": rs[cnt].kind = 6'd2;
                            "}": rs[cnt].kind = 6'd3;
                            ",": rs[cnt].kind = 6'd4;
                            ".": rs[cnt].kind = 6'd5;
                            ";": rs[cnt].kind = 6'd6;
                            default: rs[cnt].kind = 6'd7;
                        endcase
                        rs[cnt].line = n_line; rs[cnt].start = lo16(r_pos);
                        rs[cnt].length = 16'd1;
                        cnt = cnt + 1'b1;
                    end
                    "\"": begin
                        n_mode = S_STRING; n_begin = after; n_len = '0;
                    end
                    "@": begin
                        n_mode = S_AT; n_begin = r_pos; n_len = 16'd1;
                        wr_en = 1'b1; wr_idx = '0;
                    end
                    default: begin
                        if (is_pair(i_byte)) begin
                            n_mode = S_OP; n_pend = i_byte; n_begin = r_pos;
                        end else if (is_alpha(i_byte)) begin
                            n_mode = S_WORD; n_begin = r_pos; n_len = 16'd1;
                            wr_en = 1'b1; wr_idx = '0;
                        end else if (is_numeral(i_byte)) begin
                            n_mode = S_NUMBER; n_begin = r_pos; n_len = 16'd1;
                        end else begin
                            rs[cnt] = '{6'd0, n_line, lo16(r_pos), 16'd0, E_BYTE, 1'b0, 1'b0};
                            cnt = cnt + 1'b1; n_err = 1'b1; n_mode = S_IDLE;
                        end
                    end
                endcase
            end

            // word prefix as it stands after this byte is kept
            for (int i = 0; i < LONGEST_KEYWORD; i++)
                if (wr_en && wr_idx == LW'(i)) pv[i] = i_byte;

            // flush at end of text
            if (e && !n_err) begin
                case (n_mode)
                    S_OP: begin
                        rs[cnt] = '{pair_single(n_pend), n_line, lo16(n_begin), 16'd1,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    S_COMMENT: if (n_line != SAT) n_line = n_line + 1'b1;
                    S_WORD: begin
                        rs[cnt] = '{word_kind(pv, n_len), n_line, lo16(n_begin), n_len,
                                    E_NONE, 1'b0, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    S_AT: begin
                        if (kw(pv, n_len, 56'("@native"), 7))
                            rs[cnt] = '{K_AT_NATIVE, n_line, lo16(n_begin), 16'd7,
                                        E_NONE, 1'b0, 1'b0};
                        else
                            rs[cnt] = '{6'd0, n_line, lo16(n_begin), 16'd0, E_AT,
                                        1'b0, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    S_NUMBER: begin
                        rs[cnt] = '{K_NUMBER, n_line, lo16(n_begin), n_len, E_NONE,
                                    1'b0, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    S_STRING, S_ESC: begin
                        rs[cnt] = '{6'd0, n_line, lo16(n_begin), 16'd0, E_STRING,
                                    1'b0, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        // closing result
        if (e) begin
            rs[cnt] = '{6'd0, n_line, lo16(after), 16'd0, E_NONE, 1'b1, 1'b0};
            cnt = cnt + 1'b1;
        end
        if (cnt != 2'd0) rs[cnt - 1'b1].last = 1'b1;
        g.count = cnt; g.r0 = rs[0]; g.r1 = rs[1]; g.r2 = rs[2];
    end

    assign o_group = g;
    assign o_push  = i_valid && i_take && g.count != 2'd0;

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE; r_pend <= '0; r_len <= '0; r_begin <= '0;
            r_pos <= '0; r_line <= 16'd1; r_err <= 1'b0;
        end else if (i_valid && i_take) begin
            if (i_end) begin
                r_mode <= S_IDLE; r_pend <= '0; r_len <= '0; r_begin <= '0;
                r_pos <= '0; r_line <= 16'd1; r_err <= 1'b0;
            end else begin
                r_mode <= n_mode; r_pend <= n_pend; r_len <= n_len; r_begin <= n_begin;
                r_line <= n_line; r_err <= n_err;
                if (r_pos != POS_MAX) r_pos <= r_pos + 1'b1;
            end
        end
    end

    // kept word prefix
    always_ff @(posedge i_clk) begin
        if (i_valid && i_take && wr_en) r_pref[wr_idx] <= i_byte;
    end

endmodule
`default_nettype wire

[rtl/stt_back.sv]
`default_nettype none
module stt_back
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  t_group           i_group,
    output logic             o_room,
    input  wire logic        i_stall,
    output logic             o_valid,
    output t_result          o_res
);

    // two-entry queue of result groups, unpacked one result per cycle unless stalled
    t_group     r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_sub;
    logic       pop_grp, take;
    t_group     head;

    assign head    = r_q[r_rp];
    assign o_valid = r_cnt != 2'd0;
    assign take    = o_valid && !i_stall;
    assign pop_grp = take && (r_sub + 2'd1 == head.count);
    assign o_room  = r_cnt != 2'd2 || pop_grp;

    always_comb begin
        case (r_sub)
            2'd0:    o_res = head.r0;
            2'd1:    o_res = head.r1;
            default: o_res = head.r2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (take) begin
                if (pop_grp) begin
                    r_sub <= '0; r_rp <= !r_rp;
                end else r_sub <= r_sub + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_grp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_group;
    end

endmodule
`default_nettype wire

[rtl/source_text_tokenizer_unit.sv]
`default_nettype none
// Streaming lexical scanner: one source byte is taken per cycle unless the
// two-group queue is full, and up to three token results come out for it,
// one per cycle while the output is not stalled. Blanks and // comments are
// dropped, keywords are matched in parallel at word end, and an error stops
// the scan until the byte marked end of text, which always yields a closing
// result. A byte that makes three results holds the output until all are out.
module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int LONGEST_KEYWORD = LONGEST_KEYWORD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_token_kind,
    output logic [15:0]      o_token_line,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic [1:0]       o_error_code,
    output logic             o_stream_done,
    output logic             o_last_of_run
);

    t_group  grp;
    t_result res;
    logic    push, room;

    stt_front #(.POSITION_BITS(POSITION_BITS), .LONGEST_KEYWORD(LONGEST_KEYWORD)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_byte(i_text_byte), .i_end(i_end_of_text),
        .i_take(room), .o_group(grp), .o_push(push)
    );

    stt_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_group(grp), .o_room(room),
        .i_stall, .o_valid, .o_res(res)
    );

    assign o_stall        = !room;
    assign o_token_kind   = res.kind;
    assign o_token_line   = res.line;
    assign o_token_start  = res.start;
    assign o_token_length = res.length;
    assign o_error_code   = res.err;
    assign o_stream_done  = res.done;
    assign o_last_of_run  = res.last;

endmodule
`default_nettype wire
